### rtl/core/fpba_pkg.sv
// Shared constants and codes for the fit-policy block allocator.
// No dependencies; the allocator core refers to it by scoped names.
package fpba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    // Port field widths
    localparam int OP_W      = 1;
    localparam int LIDX_W    = 5;
    localparam int FSIZE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int BLOCK_W   = 5;
    localparam int REM_W     = 16;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

    // Result status codes carried in m_tuser
    typedef enum logic [STATUS_W-1:0] {
        STATUS_LOADED    = 2'd0,
        STATUS_ALLOCATED = 2'd1,
        STATUS_NO_FIT    = 2'd2
    } status_t;

    // Fit policies; the unused code behaves as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // Reset values
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 6'd32;

endpackage

### rtl/core/fit_policy_block_allocator_unit.sv
// Fit-policy block allocator: free-size table, scan sequencer and output register.
// Depends on fpba_pkg (constants, status codes, fit policies).
//
//  Channel   Direction  Transfer when            Contents
//  s_axis    in         s_tvalid & s_tready      tuser: op; tdata: load_index, size
//  m_axis    out        m_tvalid & m_tready      tuser: status; tdata: chosen_block, remaining
//  cfg       in         cfg_wr_en                cfg_addr: register, cfg_wdata: value
//
// A load goes from transfer to ST_OUT, which posts it. A request scans the first block_count
// entries (at most 32): one comparator checks one table entry per cycle behind a registered
// table read; at scan end the grant is written back, and ST_OUT posts the result once the
// output register is free. The next item can transfer in the cycle after that, at the earliest.
// Reset is synchronous; the table reads as zero until each entry is loaded.
// s_tready is low while an item is in flight; a stalled result holds in the output
// register and the next item is taken as soon as the sequencer returns to idle.
module fit_policy_block_allocator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpba_pkg::OP_W-1:0]         s_tuser,   // [0] op
    input  logic [fpba_pkg::S_TDATA_W-1:0]    s_tdata,   // [4:0] load_index, [20:5] size
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpba_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
    output logic [fpba_pkg::M_TDATA_W-1:0]    m_tdata,   // [4:0] chosen_block, [20:5] remaining
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [fpba_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

    localparam int NB  = fpba_pkg::NUM_BLOCKS;
    localparam int SB  = fpba_pkg::SIZE_BITS;
    localparam int IB  = fpba_pkg::IDX_BITS;
    localparam int CB  = fpba_pkg::CNT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [fpba_pkg::MODE_W-1:0]  fit_mode_reg;
    logic [fpba_pkg::COUNT_W-1:0] block_count_reg;

    // free-size table with per-entry valid bits
    logic [SB-1:0] mem [NB];
    logic [NB-1:0] valid_reg;
    logic          mem_we;
    logic [IB-1:0] mem_waddr;
    logic [SB-1:0] mem_wdata;
    logic [IB-1:0] rd_addr;
    logic [SB-1:0] rd_data_reg;
    logic          rd_vld_reg;

    // scan sequencer
    logic [CB-1:0] issue_cnt_reg;
    logic [CB-1:0] limit_reg;
    logic          cmp_pend_reg;
    logic [IB-1:0] cmp_idx_reg;
    logic [SB-1:0] req_reg;
    logic [fpba_pkg::MODE_W-1:0] mode_reg;
    logic          found_reg;
    logic [IB-1:0] best_idx_reg;
    logic [SB-1:0] best_size_reg;

    // pending result
    fpba_pkg::status_t              res_status_reg;
    logic [fpba_pkg::BLOCK_W-1:0]   res_block_reg;
    logic [fpba_pkg::REM_W-1:0]     res_rem_reg;

    // output register
    logic                           m_tvalid_reg;
    logic [fpba_pkg::STATUS_W-1:0]  m_tuser_reg;
    logic [fpba_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // unpacked input fields
    logic [fpba_pkg::LIDX_W-1:0]  in_index;
    logic [fpba_pkg::FSIZE_W-1:0] in_size;
    logic [SB-1:0]                in_size_trim;
    logic                         in_range;
    logic                         s_accept;
    logic                         out_free;

    // comparator path
    logic [SB-1:0] cur_size;
    logic          fits;
    logic          take;
    logic          issue;
    logic          scan_done;
    logic [SB-1:0] granted_rem;
    logic [CB-1:0] limit_next;

    assign in_index     = s_tdata[fpba_pkg::LIDX_W-1:0];
    assign in_size      = s_tdata[fpba_pkg::LIDX_W +: fpba_pkg::FSIZE_W];
    assign in_size_trim = SB'(in_size);
    assign in_range     = (32'(in_index) < NB);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // Saturate the block count at the table depth
    always_comb begin
        if (32'(block_count_reg) > NB) begin
            limit_next = CB'(NB);
        end else begin
            limit_next = CB'(block_count_reg);
        end
    end

    // Compare the entry read last cycle against the request and the best so far
    assign cur_size = rd_vld_reg ? rd_data_reg : '0;
    assign fits     = (req_reg <= cur_size);
    always_comb begin
        take = 1'b0;
        if (cmp_pend_reg && fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (mode_reg == fpba_pkg::MODE_BEST) begin
                take = (cur_size < best_size_reg);
            end else if (mode_reg == fpba_pkg::MODE_WORST) begin
                take = (cur_size > best_size_reg);
            end
        end
    end

    assign issue       = (state_reg == ST_SCAN) && (issue_cnt_reg < limit_reg);
    assign scan_done   = (state_reg == ST_SCAN) && !issue && !cmp_pend_reg;
    assign rd_addr     = issue_cnt_reg[IB-1:0];
    assign granted_rem = best_size_reg - req_reg;

    // Table write: loads at transfer, grants at the end of the scan
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = granted_rem;
        if (s_accept && (s_tuser == fpba_pkg::OP_LOAD)) begin
            mem_we    = in_range;
            mem_waddr = IB'(in_index);
            mem_wdata = in_size_trim;
        end else if (scan_done && found_reg) begin
            mem_we = 1'b1;
        end
    end

    // Table storage and registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits: an entry never loaded reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg    <= fpba_pkg::MODE_FIRST;
            block_count_reg <= fpba_pkg::BLOCK_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                fpba_pkg::CFG_FIT_MODE:    fit_mode_reg    <= cfg_wdata[fpba_pkg::MODE_W-1:0];
                fpba_pkg::CFG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer, result staging and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            found_reg     <= 1'b0;
            issue_cnt_reg <= '0;
        end else begin
            // drop the result once it has been taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser == fpba_pkg::OP_LOAD) begin
                            res_status_reg <= fpba_pkg::STATUS_LOADED;
                            res_block_reg  <= in_index;
                            res_rem_reg    <= in_range ? fpba_pkg::REM_W'(in_size_trim) : '0;
                            state_reg      <= ST_OUT;
                        end else begin
                            req_reg       <= in_size_trim;
                            mode_reg      <= fit_mode_reg;
                            limit_reg     <= limit_next;
                            issue_cnt_reg <= '0;
                            cmp_pend_reg  <= 1'b0;
                            found_reg     <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    // advance the read pointer and track the read in flight
                    if (issue) begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        cmp_idx_reg   <= issue_cnt_reg[IB-1:0];
                    end
                    cmp_pend_reg <= issue;
                    if (take) begin
                        found_reg     <= 1'b1;
                        best_idx_reg  <= cmp_idx_reg;
                        best_size_reg <= cur_size;
                    end
                    if (scan_done) begin
                        if (found_reg) begin
                            res_status_reg <= fpba_pkg::STATUS_ALLOCATED;
                            res_block_reg  <= fpba_pkg::BLOCK_W'(best_idx_reg);
                            res_rem_reg    <= fpba_pkg::REM_W'(granted_rem);
                        end else begin
                            res_status_reg <= fpba_pkg::STATUS_NO_FIT;
                            res_block_reg  <= '0;
                            res_rem_reg    <= '0;
                        end
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {
                            {(fpba_pkg::M_TDATA_W - fpba_pkg::BLOCK_W - fpba_pkg::REM_W){1'b0}},
                            res_rem_reg, res_block_reg};
                        state_reg    <= ST_IDLE;
                    end else if (m_tvalid_reg && m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### bench/fit_policy_block_allocator_unit_test.sv
// Self-checking bench for fit_policy_block_allocator_unit: directed and random load
// and request traffic, with a per-item predictor of the free-size table.
// Depends on fpba_pkg and the allocator RTL only.
module fit_policy_block_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        fpba_pkg::status_t                status;
        logic [fpba_pkg::BLOCK_W-1:0]     block;
        logic [fpba_pkg::REM_W-1:0]       remaining;
    } alloc_result_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [fpba_pkg::OP_W-1:0]        s_tuser   = '0;    // [0] op
    logic [fpba_pkg::S_TDATA_W-1:0]   s_tdata   = '0;    // [4:0] load_index, [20:5] size
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [fpba_pkg::STATUS_W-1:0]    m_tuser;           // [1:0] status
    logic [fpba_pkg::M_TDATA_W-1:0]   m_tdata;           // [4:0] chosen_block, [20:5] remaining
    logic                             cfg_wr_en = 1'b0;
    logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [fpba_pkg::CFG_DAT_W-1:0]   cfg_wdata = '0;

    // Predictor state: free sizes and register copies
    logic [fpba_pkg::SIZE_BITS-1:0]   free_table [fpba_pkg::NUM_BLOCKS];
    logic [fpba_pkg::MODE_W-1:0]      fit_mode_q;
    logic [fpba_pkg::COUNT_W-1:0]     block_count_q;

    alloc_result_t          pending_results [$];
    int                     mismatch_count = 0;
    int                     idle_cycles    = 0;
    bit                     tx_idle        = 1'b0;
    bit                     rx_idle        = 1'b0;
    int                     rx_hold_cycles = 0;

    fit_policy_block_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Apply one item to the table copy and return the result it must produce
    function automatic alloc_result_t predict_allocation(
            input logic [fpba_pkg::OP_W-1:0]    op,
            input logic [fpba_pkg::LIDX_W-1:0]  idx,
            input logic [fpba_pkg::FSIZE_W-1:0] sz);
        alloc_result_t r;
        int            in_use;
        bit            found;
        int            pick;
        if (op == fpba_pkg::OP_LOAD) begin
            free_table[idx] = sz;
            r.status    = fpba_pkg::STATUS_LOADED;
            r.block     = idx;
            r.remaining = sz;
            return r;
        end
        in_use = (block_count_q > fpba_pkg::NUM_BLOCKS) ?
                 fpba_pkg::NUM_BLOCKS : int'(block_count_q);
        found  = 1'b0;
        pick   = 0;
        for (int i = 0; i < in_use; i++) begin
            if (sz > free_table[i])
                continue;
            if (!found) begin
                found = 1'b1;
                pick  = i;
                if (fit_mode_q != fpba_pkg::MODE_BEST && fit_mode_q != fpba_pkg::MODE_WORST)
                    break;
            end else if (fit_mode_q == fpba_pkg::MODE_BEST) begin
                if (free_table[i] < free_table[pick])
                    pick = i;
            end else if (fit_mode_q == fpba_pkg::MODE_WORST) begin
                if (free_table[i] > free_table[pick])
                    pick = i;
            end
        end
        if (found) begin
            free_table[pick] = free_table[pick] - sz;
            r.status    = fpba_pkg::STATUS_ALLOCATED;
            r.block     = fpba_pkg::BLOCK_W'(pick);
            r.remaining = free_table[pick];
        end else begin
            r.status    = fpba_pkg::STATUS_NO_FIT;
            r.block     = '0;
            r.remaining = '0;
        end
        return r;
    endfunction

    // Offer one item, after a random gap when tx_idle is set; leave tvalid high once it transfers
    task automatic send_item(input logic [fpba_pkg::OP_W-1:0]    op,
                             input logic [fpba_pkg::LIDX_W-1:0]  idx,
                             input logic [fpba_pkg::FSIZE_W-1:0] sz);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, sz, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_allocation(op, idx, sz));
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [fpba_pkg::CFG_DAT_W-1:0] mode_val,
                              input logic [fpba_pkg::CFG_DAT_W-1:0] count_val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= fpba_pkg::CFG_FIT_MODE;
        cfg_wdata <= mode_val;
        @(posedge aclk);
        fit_mode_q = mode_val[fpba_pkg::MODE_W-1:0];
        cfg_addr  <= fpba_pkg::CFG_BLOCK_COUNT;
        cfg_wdata <= count_val;
        @(posedge aclk);
        block_count_q = count_val;
        cfg_wr_en <= 1'b0;
    endtask

    // Requests against the all-zero table left by reset
    task automatic test_empty_table();
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd0);
        send_item(fpba_pkg::OP_REQUEST, 5'd31, 16'd1);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'hFFFF);
    endtask

    // Extreme loads, then first-fit grants
    task automatic test_first_fit();
        send_item(fpba_pkg::OP_LOAD, 5'd0, 16'hFFFF);
        send_item(fpba_pkg::OP_LOAD, 5'd31, 16'h8000);
        send_item(fpba_pkg::OP_LOAD, 5'd5, 16'd100);
        send_item(fpba_pkg::OP_LOAD, 5'd10, 16'd50);
        send_item(fpba_pkg::OP_LOAD, 5'd20, 16'd200);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd60);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'hFFFF);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'h8000);
    endtask

    // Best, worst and the unused mode code, which acts as first fit
    task automatic test_fit_modes();
        set_config(fpba_pkg::CFG_DAT_W'(fpba_pkg::MODE_BEST), 6'd32);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd40);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd0);
        set_config({4'b1111, fpba_pkg::MODE_WORST}, 6'd32);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd10);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd10);
        set_config(6'd3, 6'd32);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd10);
    endtask

    // Count of zero, a load outside the searched range, and a saturating count
    task automatic test_block_count_edges();
        set_config(fpba_pkg::CFG_DAT_W'(fpba_pkg::MODE_FIRST), 6'd0);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'd0);
        set_config(fpba_pkg::CFG_DAT_W'(fpba_pkg::MODE_WORST), 6'd1);
        send_item(fpba_pkg::OP_LOAD, 5'd31, 16'hFFFF);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'h1000);
        set_config(fpba_pkg::CFG_DAT_W'(fpba_pkg::MODE_WORST), 6'd63);
        send_item(fpba_pkg::OP_REQUEST, 5'd0, 16'h7000);
    endtask

    // Mostly loads into blocks in use and modest requests, some full-range noise
    task automatic test_random_traffic(input int n_items);
        logic [fpba_pkg::OP_W-1:0]    op;
        logic [fpba_pkg::LIDX_W-1:0]  idx;
        logic [fpba_pkg::FSIZE_W-1:0] sz;
        int                           in_use;
        in_use = (block_count_q > fpba_pkg::NUM_BLOCKS) ?
                 fpba_pkg::NUM_BLOCKS : int'(block_count_q);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 40) begin
                op  = fpba_pkg::OP_LOAD;
                idx = (in_use == 0 || $urandom_range(0, 9) == 0) ?
                      fpba_pkg::LIDX_W'($urandom) :
                      fpba_pkg::LIDX_W'($urandom_range(0, in_use - 1));
                case ($urandom_range(0, 9))
                    0:       sz = 16'hFFFF;
                    1:       sz = 16'd0;
                    2, 3:    sz = 16'($urandom);
                    default: sz = 16'($urandom_range(0, 3000));
                endcase
            end else begin
                op  = fpba_pkg::OP_REQUEST;
                idx = fpba_pkg::LIDX_W'($urandom);
                case ($urandom_range(0, 9))
                    0:       sz = 16'($urandom);
                    1:       sz = 16'd0;
                    default: sz = 16'($urandom_range(1, 700));
                endcase
            end
            send_item(op, idx, sz);
        end
    endtask

    // Random phases over several settings, idling switched per phase
    task automatic test_random_phases();
        logic [fpba_pkg::CFG_DAT_W-1:0] counts [11];
        counts = '{6'd32, 6'd1, 6'd2, 6'd7, 6'd0, 6'd63, 6'd33, 6'd16, 6'd31, 6'd5, 6'd32};
        foreach (counts[p]) begin
            set_config({4'($urandom), 2'($urandom)}, counts[p]);
            tx_idle = (p % 3 != 0) && $urandom_range(0, 1);
            rx_idle = (p % 3 != 0) && $urandom_range(0, 1);
            test_random_traffic(85);
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_output_stall();
        set_config(fpba_pkg::CFG_DAT_W'(fpba_pkg::MODE_BEST), 6'd8);
        tx_idle = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        test_random_traffic(20);
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_sender_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_random_traffic(10);
        drain_results();
        test_random_traffic(10);
    endtask

    // Result sink: random or long hold-off before each transfer
    initial begin : result_sink
        int wait_cycles;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            wait_cycles = rx_idle ? $urandom_range(0, 12) : 0;
            if (rx_hold_cycles > 0) begin
                wait_cycles    = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result: status %0d block %0d remaining %0d",
                         $time, m_tuser, m_tdata[4:0], m_tdata[20:5]);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    mismatch_count++;
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata[4:0] !== want.block) begin
                    mismatch_count++;
                    $display("%0t chosen_block: expected %0d actual %0d",
                             $time, want.block, m_tdata[4:0]);
                end
                if (m_tdata[20:5] !== want.remaining) begin
                    mismatch_count++;
                    $display("%0t remaining_after: expected %0d actual %0d",
                             $time, want.remaining, m_tdata[20:5]);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fit_mode_q    = fpba_pkg::MODE_FIRST;
        block_count_q = fpba_pkg::BLOCK_COUNT_RST;
        foreach (free_table[i]) free_table[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_first_fit();
        test_fit_modes();
        test_block_count_edges();
        test_output_stall();
        test_random_phases();
        test_sender_pause();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
